// ----- rtl/pos_pkg.sv -----
// Shared types and constants of the pulse odometer and speed block.
// No dependencies; every other file of the block imports this package.
package pos_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int UM_W       = 17;
  localparam int DIST_W     = 48;
  localparam int SPEED_W    = 33;
  localparam int CMD_DIFF_W = 32;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = 1;
  localparam int Q_CNT_W    = 2;

  localparam logic [UM_W-1:0]    UM_RESET  = 17'd19735;
  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  // Input item
  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] count_sample;
  } pos_in_t;

  // Result item
  typedef struct packed {
    logic [DIST_W-1:0]  total_distance_um;
    logic [SPEED_W-1:0] speed_mkmh;
  } pos_out_t;

  // Classified command from the front to the back
  typedef struct packed {
    logic                  is_clear;
    logic [CMD_DIFF_W-1:0] step_diff;
    logic [CMD_DIFF_W-1:0] win_diff;
  } pos_cmd_t;

  // Queue status
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } pos_q_stat_t;

  // Back-end status
  typedef struct packed {
    logic pop;
    logic busy;
  } pos_back_stat_t;

endpackage

// ----- rtl/pos_front.sv -----
// Front end: accepts samples, keeps the sample history and forms pulse differences.
// Depends on pos_pkg.
module pos_front import pos_pkg::*; #(
  parameter int WINDOW       = 3,
  parameter int COUNTER_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pos_in_t  in_data,
  input  logic     q_full,
  output logic     push,
  output pos_cmd_t cmd
);

  localparam int SAMP_W = (COUNTER_BITS < SAMPLE_W) ? COUNTER_BITS : SAMPLE_W;
  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [SAMP_W-1:0]       prev_r;
  logic [SAMP_W-1:0]       ring_r [WINDOW];
  logic [PTR_W-1:0]        ptr_r;
  logic [PTR_W-1:0]        ptr_nxt;
  logic [SAMP_W-1:0]       samp;
  logic [COUNTER_BITS-1:0] step_diff;
  logic [COUNTER_BITS-1:0] win_diff;

  // Stall while the queue has no room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Wrap-aware differences against the previous and the oldest sample
  assign samp      = in_data.count_sample[SAMP_W-1:0];
  assign step_diff = COUNTER_BITS'(samp) - COUNTER_BITS'(prev_r);
  assign win_diff  = COUNTER_BITS'(samp) - COUNTER_BITS'(ring_r[ptr_r]);
  assign ptr_nxt   = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;

  assign cmd.is_clear  = in_data.mode;
  assign cmd.step_diff = CMD_DIFF_W'(step_diff);
  assign cmd.win_diff  = CMD_DIFF_W'(win_diff);

  // Update history: a clear item loads every slot, a tick replaces the oldest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      ptr_r  <= '0;
      for (int i = 0; i < WINDOW; i++) ring_r[i] <= '0;
    end else if (push) begin
      prev_r <= samp;
      if (in_data.mode) begin
        ptr_r <= '0;
        for (int i = 0; i < WINDOW; i++) ring_r[i] <= samp;
      end else begin
        ring_r[ptr_r] <= samp;
        ptr_r         <= ptr_nxt;
      end
    end
  end

endmodule

// ----- rtl/pos_queue.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on pos_pkg.
module pos_queue import pos_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  pos_cmd_t    cmd_in,
  input  logic        pop,
  output pos_cmd_t    cmd_out,
  output pos_q_stat_t stat
);

  pos_cmd_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign cmd_out    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= cmd_in;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- rtl/pos_back.sv -----
// Back end: scales differences, accumulates distance, divides out the speed.
// Holds the result register; depends on pos_pkg.
module pos_back import pos_pkg::*; #(
  parameter int WINDOW       = 3,
  parameter int COUNTER_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [UM_W-1:0] um_per_pulse,
  input  logic           q_empty,
  input  pos_cmd_t       q_head,
  output pos_back_stat_t stat,
  output logic           out_valid,
  input  logic           out_stall,
  output pos_out_t       out_data
);

  localparam int PROD_W  = COUNTER_BITS + UM_W;
  localparam int SUM_W   = ((PROD_W > DIST_W) ? PROD_W : DIST_W) + 1;
  localparam int NUM_W   = PROD_W + 6;
  localparam int DIVISOR = 10000 * WINDOW;
  localparam int DIV_W   = $clog2(DIVISOR);
  // Quotient digit width so that remainder and digit fill 32 bits
  localparam int DIG_W   = 32 - DIV_W;
  localparam int DIGITS  = (NUM_W + DIG_W - 1) / DIG_W;
  localparam int QUO_W   = DIGITS * DIG_W;
  localparam int CNT_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int QEXT_W  = (QUO_W > SPEED_W) ? QUO_W : SPEED_W + 1;
  // Reciprocal ceil(2^RCP_S / DIVISOR), exact for any 32-bit partial dividend
  localparam int RCP_S   = 32 + DIV_W;
  localparam longint unsigned RCP_M_L = ((64'd1 << RCP_S) + DIVISOR - 1) / DIVISOR;
  localparam logic [32:0]      RCP_M     = 33'(RCP_M_L);
  localparam logic [DIV_W-1:0] DIVISOR_D = DIV_W'(DIVISOR);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_MUL_STEP = 7'b0000010,
    ST_MUL_WIN  = 7'b0000100,
    ST_SCALE    = 7'b0001000,
    ST_DIV      = 7'b0010000,
    ST_REM      = 7'b0100000,
    ST_DONE     = 7'b1000000
  } back_state_t;

  back_state_t             state_r;
  logic [COUNTER_BITS-1:0] step_r;
  logic [COUNTER_BITS-1:0] win_r;
  logic [PROD_W-1:0]       prod_r;
  logic [DIST_W-1:0]       dist_r;
  logic [QUO_W-1:0]        num_r;
  logic [QUO_W-1:0]        quot_r;
  logic [DIG_W-1:0]        dig_r;
  logic [DIV_W-1:0]        rem_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    out_valid_r;
  pos_out_t                out_data_r;

  logic                    slot_free;
  logic                    pop;
  logic [SUM_W-1:0]        sum;
  logic [31:0]             part;
  logic [64:0]             rcp_prod;
  logic [DIG_W-1:0]        digit;
  logic [31:0]             back_prod;
  logic [31:0]             rem_full;
  logic [QEXT_W-1:0]       qext;
  logic [SPEED_W-1:0]      speed;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = (state_r == ST_IDLE) && !q_empty && slot_free;
  assign stat.pop  = pop;
  assign stat.busy = (state_r != ST_IDLE);

  // Saturating distance add
  assign sum = SUM_W'(dist_r) + SUM_W'(prod_r);

  // One quotient digit per ST_DIV/ST_REM pair: reciprocal multiply, then remainder
  assign part      = {rem_r, num_r[QUO_W-1 -: DIG_W]};
  assign rcp_prod  = {33'b0, part} * {32'b0, RCP_M};
  assign digit     = rcp_prod[RCP_S +: DIG_W];
  assign back_prod = 32'(dig_r) * 32'(DIVISOR_D);
  assign rem_full  = part - back_prod;

  // Clamp the quotient to the speed field
  assign qext  = QEXT_W'(quot_r);
  assign speed = (qext[QEXT_W-1:SPEED_W] != '0) ? SPEED_MAX : qext[SPEED_W-1:0];

  // Sequence one command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dist_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            if (q_head.is_clear) begin
              dist_r <= '0;
            end else begin
              step_r  <= q_head.step_diff[COUNTER_BITS-1:0];
              win_r   <= q_head.win_diff[COUNTER_BITS-1:0];
              state_r <= ST_MUL_STEP;
            end
          end
        end
        ST_MUL_STEP: begin
          prod_r  <= step_r * um_per_pulse;
          state_r <= ST_MUL_WIN;
        end
        ST_MUL_WIN: begin
          dist_r  <= (sum[SUM_W-1:DIST_W] != '0) ? DIST_MAX : sum[DIST_W-1:0];
          prod_r  <= win_r * um_per_pulse;
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          num_r   <= (QUO_W'(prod_r) << 5) + (QUO_W'(prod_r) << 2);
          quot_r  <= '0;
          rem_r   <= '0;
          cnt_r   <= CNT_W'(DIGITS - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          dig_r   <= digit;
          state_r <= ST_REM;
        end
        ST_REM: begin
          rem_r  <= rem_full[DIV_W-1:0];
          num_r  <= num_r << DIG_W;
          quot_r <= (quot_r << DIG_W) | QUO_W'(dig_r);
          if (cnt_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= ST_DIV;
          end
        end
        ST_DONE: begin
          if (slot_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output register: load a result when the slot is free, drop it on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && q_head.is_clear) begin
      out_valid_r <= 1'b1;
    end else if ((state_r == ST_DONE) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_head.is_clear) begin
      out_data_r.total_distance_um <= '0;
      out_data_r.speed_mkmh        <= '0;
    end else if ((state_r == ST_DONE) && slot_free) begin
      out_data_r.total_distance_um <= dist_r;
      out_data_r.speed_mkmh        <= speed;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/pulse_odometer_speed.sv -----
// Wheel-pulse odometer with windowed speed: front end, command queue, back end.
// Top level; depends on pos_pkg, pos_front, pos_queue and pos_back.
//
// Each input item is one sample of a free-running wheel-pulse counter taken once per
// second (mode 0) or a clear of distance and history (mode 1). Every item gives one
// result: the saturating 48-bit distance in micrometres and the speed in 0.001 km/h
// over the last WINDOW samples. The front end takes one item per cycle, while the
// queue has room, into a two-entry queue. A clear item loads a zero result as it is
// popped. A sample item runs through the pop in ST_IDLE, ST_MUL_STEP, ST_MUL_WIN,
// ST_SCALE, an ST_DIV/ST_REM pair per quotient digit of the reciprocal divider by
// 10000*WINDOW, and ST_DONE, which loads the output register. DIGITS is the number
// of (32 - ceil(log2(10000*WINDOW)))-bit digits in the (COUNTER_BITS + 23)-bit
// scaled product, three at the defaults. The back end pops only in ST_IDLE, so its
// sequence sets the sustained rate; a stalled result holds it in ST_DONE. The user
// must write um_per_pulse only while the block is idle; the block does not enforce it.
module pulse_odometer_speed import pos_pkg::*; #(
  parameter int WINDOW       = 3,
  parameter int COUNTER_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pos_in_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output pos_out_t        out_data,
  input  logic            cfg_we,
  input  logic [UM_W-1:0] cfg_wdata
);

  logic [UM_W-1:0] um_per_pulse_r;
  logic            push;
  pos_cmd_t        front_cmd;
  pos_cmd_t        q_head;
  pos_q_stat_t     q_stat;
  pos_back_stat_t  back_stat;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      um_per_pulse_r <= UM_RESET;
    end else if (cfg_we) begin
      um_per_pulse_r <= cfg_wdata;
    end
  end

  pos_front #(
    .WINDOW       (WINDOW),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_stat.full),
    .push     (push),
    .cmd      (front_cmd)
  );

  pos_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (front_cmd),
    .pop     (back_stat.pop),
    .cmd_out (q_head),
    .stat    (q_stat)
  );

  pos_back #(
    .WINDOW       (WINDOW),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .um_per_pulse (um_per_pulse_r),
    .q_empty      (q_stat.empty),
    .q_head       (q_head),
    .stat         (back_stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

`ifndef SYNTHESIS
  // Queue occupancy stays within its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue occupancy beyond depth");

  // The back end only takes a command that is there
  assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // A clear command shows a zero result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.pop && q_head.is_clear |=>
      out_valid && (out_data.total_distance_um == '0) && (out_data.speed_mkmh == '0))
    else $error("clear did not give a zero result");

  // The register changes only while the back end is idle
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !back_stat.busy)
    else $error("um_per_pulse written while busy");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the wheel-pulse odometer with windowed speed.
// Depends on pos_pkg and pulse_odometer_speed; runs directed rows, random phases
// and a back-to-back run at the largest step, all checked against a built-in predictor.
module tb_top;
  import pos_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN            = 3;
  localparam int CNT_BITS       = 16;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 230;
  localparam int SAT_ITEMS      = 40;
  localparam int PRESSURE_AT    = 120;
  localparam int PRESSURE_HOLD  = 600;
  localparam int DRAIN_CYCLES   = 60;
  localparam int MAX_REPORTS    = 20;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic {ROW_ITEM, ROW_UM} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic                mode;
    logic [UM_W-1:0]     val;
    bit                  known;
    logic [DIST_W-1:0]   want_dist;
    logic [SPEED_W-1:0]  speed;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  pos_in_t         in_data;
  logic            out_valid;
  logic            out_stall;
  pos_out_t        out_data;
  logic            cfg_we;
  logic [UM_W-1:0] cfg_wdata;

  // Predictor state
  logic [UM_W-1:0]     odo_um;
  logic [SAMPLE_W-1:0] odo_prev;
  logic [SAMPLE_W-1:0] odo_ring [WIN];
  int unsigned         odo_slot;
  logic [DIST_W-1:0]   odo_dist;

  pos_out_t    odo_expected [$];
  dir_row_t    dir_rows [$];
  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  bit          gap_on       = 1'b0;
  bit          stall_on     = 1'b0;

  always #5 clk = ~clk;

  pulse_odometer_speed #(
    .WINDOW       (WIN),
    .COUNTER_BITS (CNT_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Advance the predictor by one item and return the result it gives
  function automatic pos_out_t odo_advance(input pos_in_t it);
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] d;
    logic [63:0]         step_um;
    logic [63:0]         win_um;
    logic [63:0]         spd;
    pos_out_t            r;
    s = it.count_sample;
    r = '0;
    if (it.mode == MODE_CLEAR) begin
      odo_dist = '0;
      odo_prev = s;
      for (int i = 0; i < WIN; i++) odo_ring[i] = s;
      odo_slot = 0;
      return r;
    end
    // accumulate the step since the previous sample, saturating
    d = s - odo_prev;
    step_um = {48'b0, d} * {47'b0, odo_um};
    if (step_um > ({16'b0, DIST_MAX} - {16'b0, odo_dist}))
      odo_dist = DIST_MAX;
    else
      odo_dist = odo_dist + step_um[DIST_W-1:0];
    // speed over the window against the oldest ring slot
    d = s - odo_ring[odo_slot];
    win_um = {48'b0, d} * {47'b0, odo_um};
    spd = (win_um * 64'd36) / (64'd10000 * WIN);
    if (spd > {31'b0, SPEED_MAX}) spd = {31'b0, SPEED_MAX};
    odo_prev = s;
    odo_ring[odo_slot] = s;
    odo_slot = (odo_slot + 1) % WIN;
    r.total_distance_um = odo_dist;
    r.speed_mkmh = spd[SPEED_W-1:0];
    return r;
  endfunction

  task automatic plan_item(input logic mode, input logic [SAMPLE_W-1:0] s);
    dir_row_t row;
    row = '{ROW_ITEM, mode, {1'b0, s}, 1'b0, '0, '0};
    dir_rows.push_back(row);
  endtask

  task automatic plan_known(input logic mode, input logic [SAMPLE_W-1:0] s,
                            input logic [DIST_W-1:0] want_dist,
                            input logic [SPEED_W-1:0] speed);
    dir_row_t row;
    row = '{ROW_ITEM, mode, {1'b0, s}, 1'b1, want_dist, speed};
    dir_rows.push_back(row);
  endtask

  task automatic plan_um(input logic [UM_W-1:0] v);
    dir_row_t row;
    row = '{ROW_UM, MODE_TICK, v, 1'b0, '0, '0};
    dir_rows.push_back(row);
  endtask

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input pos_in_t it);
    int unsigned gap;
    gap = gap_on ? $urandom_range(0, 13) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Predict, record and send one item; a known result overrides the prediction
  task automatic run_item(input logic mode, input logic [SAMPLE_W-1:0] s, input bit known,
                          input logic [DIST_W-1:0] want_dist,
                          input logic [SPEED_W-1:0] speed);
    pos_in_t  it;
    pos_out_t want;
    it.mode = mode;
    it.count_sample = s;
    want = odo_advance(it);
    if (known) begin
      want.total_distance_um = want_dist;
      want.speed_mkmh = speed;
    end
    odo_expected.push_back(want);
    send_item(it);
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (odo_expected.size() != 0) @(posedge clk);
  endtask

  // Write um_per_pulse once the block is idle
  task automatic write_um(input logic [UM_W-1:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    odo_um = v;
  endtask

  // Result side: random stall before each transfer, one long hold-off
  initial begin : result_side
    int unsigned hold;
    bit          pressure_done;
    pressure_done = 1'b0;
    out_stall = 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        hold = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end else begin
        hold = stall_on ? $urandom_range(0, 13) : 0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    pos_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (odo_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result dist=%0d speed=%0d", $time,
                   out_data.total_distance_um, out_data.speed_mkmh);
      end else begin
        want = odo_expected.pop_front();
        if (out_data.total_distance_um !== want.total_distance_um) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: distance expected %0d actual %0d", $time,
                     want.total_distance_um, out_data.total_distance_um);
        end
        if (out_data.speed_mkmh !== want.speed_mkmh) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: speed expected %0d actual %0d", $time,
                     want.speed_mkmh, out_data.speed_mkmh);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t            row;
    logic [UM_W-1:0]     phase_um [PHASES];
    logic [SAMPLE_W-1:0] s;
    logic                mode;
    int unsigned         pick;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;

    // predictor reset state
    odo_um   = UM_RESET;
    odo_prev = '0;
    for (int i = 0; i < WIN; i++) odo_ring[i] = '0;
    odo_slot = 0;
    odo_dist = '0;

    // directed rows: counter wrap, zero step, clears, register extremes
    plan_known(MODE_TICK,  16'h0000, '0, '0);
    plan_item (MODE_TICK,  16'h0001);
    plan_item (MODE_TICK,  16'hFFFF);
    plan_item (MODE_TICK,  16'h0000);
    plan_item (MODE_TICK,  16'h0003);
    plan_known(MODE_CLEAR, 16'hFFFF, '0, '0);
    plan_known(MODE_TICK,  16'hFFFF, '0, '0);
    plan_item (MODE_TICK,  16'h0000);
    plan_item (MODE_TICK,  16'h7FFF);
    plan_item (MODE_TICK,  16'hFFFE);
    plan_um(17'd0);
    plan_known(MODE_CLEAR, 16'h0000, '0, '0);
    plan_known(MODE_TICK,  16'hFFFF, '0, '0);
    plan_known(MODE_TICK,  16'h1234, '0, '0);
    plan_um(17'h1FFFF);
    plan_known(MODE_CLEAR, 16'h0001, '0, '0);
    plan_item (MODE_TICK,  16'h0000);
    plan_item (MODE_TICK,  16'hFFFF);
    plan_item (MODE_TICK,  16'hFFFE);
    plan_item (MODE_TICK,  16'hFFFD);
    plan_um(17'd1);
    plan_known(MODE_CLEAR, 16'h5555, '0, '0);
    plan_item (MODE_TICK,  16'hAAAA);
    plan_item (MODE_TICK,  16'h5555);
    plan_um(17'd100000);
    plan_item (MODE_TICK,  16'hAAAA);
    plan_item (MODE_TICK,  16'h5554);
    plan_known(MODE_CLEAR, 16'hAAAA, '0, '0);
    plan_item (MODE_TICK,  16'hAAAB);

    // hold reset, then release
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed rows with idling on both sides
    gap_on   = 1'b1;
    stall_on = 1'b1;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_UM)
        write_um(row.val);
      else
        run_item(row.mode, row.val[SAMPLE_W-1:0], row.known, row.want_dist, row.speed);
    end

    // random phases, one register setting each
    phase_um[0] = UM_RESET;
    phase_um[1] = 17'd0;
    phase_um[2] = 17'd1;
    phase_um[3] = 17'd100000;
    phase_um[4] = 17'h1FFFF;
    phase_um[5] = UM_W'($urandom_range(2, 131070));
    phase_um[6] = UM_W'($urandom_range(2, 131070));
    for (int p = 0; p < PHASES; p++) begin
      write_um(phase_um[p]);
      gap_on   = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = ($urandom_range(0, 19) == 0) ? MODE_CLEAR : MODE_TICK;
        pick = $urandom_range(0, 99);
        // mostly plausible wheel motion, some wrap extremes and noise
        if (pick < 50)      s = odo_prev + 16'($urandom_range(0, 40));
        else if (pick < 65) s = 16'($urandom_range(0, 65535));
        else if (pick < 75) s = odo_prev - 16'd1;
        else if (pick < 85) s = odo_prev;
        else                s = odo_prev + 16'($urandom_range(1000, 4000));
        run_item(mode, s, 1'b0, '0, '0);
      end
    end

    // run the largest step per item back to back
    write_um(17'h1FFFF);
    gap_on   = 1'b0;
    stall_on = 1'b0;
    s = '0;
    run_item(MODE_CLEAR, s, 1'b1, '0, '0);
    for (int n = 0; n < SAT_ITEMS; n++) begin
      s = s - 16'd1;
      run_item(MODE_TICK, s, 1'b0, '0, '0);
    end
    gap_on   = 1'b1;
    stall_on = 1'b1;
    for (int n = 0; n < 20; n++)
      run_item(MODE_TICK, 16'($urandom_range(0, 65535)), 1'b0, '0, '0);

    // let the pipe empty, then give the verdict
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (odo_expected.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, odo_expected.size());
    end
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #100ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ----- pulse_odometer_speed.f -----
rtl/pos_pkg.sv
rtl/pos_front.sv
rtl/pos_queue.sv
rtl/pos_back.sv
rtl/pulse_odometer_speed.sv
bench/tb_top.sv
